@@ rtl/pwlr_pkg.sv @@
`timescale 1ns / 1ps
package pwlr_pkg;

    localparam int UNIT_W    = 12;
    localparam int MAXB_W    = 9;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int DATA_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int BCOUNT_W  = 9;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 12'd100;
    localparam logic [MAXB_W-1:0] MAXB_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES  = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SIZE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMING = 2'd2;

    typedef struct packed {
        logic                kind;
        logic [DATA_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
        logic [BCOUNT_W-1:0] byte_count;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push;

endpackage

@@ rtl/pwlr_in_if.sv @@
`timescale 1ns / 1ps
interface pwlr_in_if;
    logic valid;
    logic ready;
    logic action;
    logic pin_level;

    modport source (output valid, output action, output pin_level, input ready);
    modport sink (input valid, input action, input pin_level, output ready);
endinterface

@@ rtl/pwlr_out_if.sv @@
`timescale 1ns / 1ps
interface pwlr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [pwlr_pkg::DATA_W-1:0]   data_byte;
    logic [pwlr_pkg::STATUS_W-1:0] status;
    logic [pwlr_pkg::BCOUNT_W-1:0] byte_count;
    logic                          last;

    modport source (output valid, output kind, output data_byte, output status,
                    output byte_count, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input status,
                  input byte_count, input last, output ready);
endinterface

@@ rtl/pwlr_decode.sv @@
`timescale 1ns / 1ps
module pwlr_decode #(
    parameter int MAX_PACKET_BYTES = 256,
    parameter int COUNT_BITS       = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pwlr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwlr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_accept,
    input  logic                             i_action,
    input  logic                             i_pin_level,
    output logic                             o_busy,
    output pwlr_pkg::t_push                  o_push
);

    localparam int EW = $clog2(MAX_PACKET_BYTES * 16 + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
    localparam logic [1:0] PH_WAIT_EDGE = 2'd2;
    localparam logic [1:0] PH_MEASURE   = 2'd3;

    function automatic logic off_tgt(input logic [31:0] iv, input logic [31:0] tg,
                                     input logic [31:0] tl);
        logic [31:0] d;
        d = (iv >= tg) ? iv - tg : tg - iv;
        return d > tl;
    endfunction

    logic [pwlr_pkg::UNIT_W-1:0] r_unit_ticks;
    logic [pwlr_pkg::MAXB_W-1:0] r_max_bytes;

    logic r_s1_valid, r_s1_action, r_s1_level;

    logic [1:0]            r_phase, n_phase;
    logic                  r_prev, n_prev;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [EW-1:0]         r_edges, n_edges;
    logic [COUNT_BITS-1:0] r_high, n_high;
    logic [7:0]            r_shift, n_shift;
    logic                  r_fault, n_fault;

    logic [13:0]           stop;
    logic [10:0]           tol;
    logic [12:0]           mb_c;
    logic [EW-1:0]         limit;
    logic [COUNT_BITS-1:0] n_val;
    logic [EW-1:0]         edge_nx;
    logic                  bit_v;
    logic [2:0]            pos;
    logic [12:0]           ht, lt;
    logic                  finish;
    logic                  byte_out;
    pwlr_pkg::t_result     res_byte, res_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= pwlr_pkg::UNIT_RESET;
            r_max_bytes  <= pwlr_pkg::MAXB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pwlr_pkg::CFG_UNIT_TICKS: r_unit_ticks <= i_cfg_data[pwlr_pkg::UNIT_W-1:0];
                pwlr_pkg::CFG_MAX_BYTES:  r_max_bytes  <= i_cfg_data[pwlr_pkg::MAXB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        if (i_accept) begin
            r_s1_action <= i_action;
            r_s1_level  <= i_pin_level;
        end
    end

    assign o_busy = r_s1_valid;

    always_comb begin
        stop = {2'b00, r_unit_ticks} + {1'b0, r_unit_ticks, 1'b0};
        tol  = r_unit_ticks[pwlr_pkg::UNIT_W-1:1];
        if (r_max_bytes == '0) begin
            mb_c = 13'd1;
        end else if ({4'b0000, r_max_bytes} > 13'(MAX_PACKET_BYTES)) begin
            mb_c = 13'(MAX_PACKET_BYTES);
        end else begin
            mb_c = {4'b0000, r_max_bytes};
        end
        limit = EW'({mb_c, 4'b0000});
    end

    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_cnt   = r_cnt;
        n_edges = r_edges;
        n_high  = r_high;
        n_shift = r_shift;
        n_fault = r_fault;
        finish   = 1'b0;
        byte_out = 1'b0;
        n_val   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        edge_nx = r_edges + 1'b1;
        bit_v   = r_high >= n_val;
        pos     = edge_nx[3:1] - 3'd1;
        ht      = bit_v ? {r_unit_ticks, 1'b0} : {1'b0, r_unit_ticks};
        lt      = bit_v ? {1'b0, r_unit_ticks} : {r_unit_ticks, 1'b0};

        if (r_s1_valid) begin
            if (r_s1_action) begin
                n_phase = PH_WAIT_LOW;
                n_prev  = 1'b0;
                n_cnt   = '0;
                n_edges = '0;
                n_high  = '0;
                n_shift = '0;
                n_fault = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_IDLE: ;
                    PH_WAIT_LOW: begin
                        if (!r_s1_level) begin
                            n_prev  = 1'b0;
                            n_phase = PH_WAIT_EDGE;
                        end
                    end
                    PH_WAIT_EDGE: begin
                        if (r_s1_level != r_prev) begin
                            n_prev  = r_s1_level;
                            n_cnt   = '0;
                            n_phase = PH_MEASURE;
                        end
                    end
                    PH_MEASURE: begin
                        n_cnt = n_val;
                        if (32'(n_val) > 32'(stop)) begin
                            finish = 1'b1;
                        end else if (r_s1_level != r_prev) begin
                            n_prev  = r_s1_level;
                            n_cnt   = '0;
                            n_edges = edge_nx;
                            if (edge_nx[0]) begin
                                n_high = n_val;
                            end else begin
                                if (off_tgt(32'(r_high), 32'(ht), 32'(tol))
                                        || off_tgt(32'(n_val), 32'(lt), 32'(tol))) begin
                                    n_fault = 1'b1;
                                end
                                n_shift = (pos == 3'd0) ? 8'h00 : r_shift;
                                n_shift[pos] = bit_v;
                                byte_out = (pos == 3'd7);
                            end
                            if (edge_nx >= limit) begin
                                finish = 1'b1;
                            end
                        end
                        if (finish) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        res_byte            = '0;
        res_byte.kind       = pwlr_pkg::KIND_BYTE;
        res_byte.data_byte  = n_shift;
        res_byte.status     = pwlr_pkg::ST_OK;
        res_byte.last       = !finish;

        res_end             = '0;
        res_end.kind        = pwlr_pkg::KIND_END;
        res_end.last        = 1'b1;
        if (n_edges[3:0] != 4'd0) begin
            res_end.status = pwlr_pkg::ST_SIZE;
        end else if (n_fault) begin
            res_end.status = pwlr_pkg::ST_TIMING;
        end else begin
            res_end.status     = pwlr_pkg::ST_OK;
            res_end.byte_count = pwlr_pkg::BCOUNT_W'(n_edges >> 4);
        end

        o_push = '0;
        if (byte_out) begin
            o_push.a_valid = 1'b1;
            o_push.a       = res_byte;
            o_push.b_valid = finish;
            o_push.b       = res_end;
        end else begin
            o_push.a_valid = finish;
            o_push.a       = res_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_prev  <= 1'b0;
            r_cnt   <= '0;
            r_edges <= '0;
            r_high  <= '0;
            r_shift <= '0;
            r_fault <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_edges <= n_edges;
            r_high  <= n_high;
            r_shift <= n_shift;
            r_fault <= n_fault;
        end
    end

endmodule

@@ rtl/pwlr_fifo.sv @@
`timescale 1ns / 1ps
module pwlr_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pwlr_pkg::t_push              i_push,
    input  logic                         i_pop,
    output logic                         o_valid,
    output pwlr_pkg::t_result            o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pwlr_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr, r_rd;
    logic [CW-1:0]     r_count;
    logic [AW-1:0]     wr_b;
    logic [1:0]        n_pushes;

    assign wr_b     = r_wr + 1'b1;
    assign n_pushes = {1'b0, i_push.a_valid} + {1'b0, i_push.b_valid};
    assign o_valid  = r_count != '0;
    assign o_head   = r_mem[r_rd];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[wr_b] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + AW'(n_pushes);
            r_rd    <= r_rd + AW'(i_pop && o_valid);
            r_count <= r_count + CW'(n_pushes) - CW'(i_pop && o_valid);
        end
    end

endmodule

@@ rtl/pulse_width_line_receiver_top.sv @@
`timescale 1ns / 1ps
// A result passes through the input register and then the result queue before it is valid.
// Throughput: one input item per cycle while ready is high; at most one result leaves per cycle.
// Ready drops while the 8-entry result queue cannot take two more results, plus two more if an item is in decode.
// Reset (synchronous, active low): receiver idle and not armed, queue empty,
// unit_ticks = 100, max_bytes = 256.
module pulse_width_line_receiver_top #(
    parameter int MAX_PACKET_BYTES = 256,
    parameter int COUNT_BITS       = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pwlr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pwlr_pkg::CFG_W-1:0]     i_cfg_data,
    pwlr_in_if.sink                        i_in_ch,
    pwlr_out_if.source                     o_out_ch
);

    localparam int QDEPTH = 8;
    localparam int QCW    = $clog2(QDEPTH + 1);

    logic              busy;
    logic              accept;
    pwlr_pkg::t_push   push;
    pwlr_pkg::t_result head;
    logic [QCW-1:0]    q_count;
    logic [QCW:0]      q_load;

    assign q_load        = {1'b0, q_count} + (busy ? (QCW+1)'(2) : '0);
    assign i_in_ch.ready = q_load <= (QCW+1)'(QDEPTH - 2);
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    pwlr_decode #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .COUNT_BITS       (COUNT_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_action    (i_in_ch.action),
        .i_pin_level (i_in_ch.pin_level),
        .o_busy      (busy),
        .o_push      (push)
    );

    pwlr_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out_ch.ready),
        .o_valid (o_out_ch.valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_out_ch.kind       = head.kind;
    assign o_out_ch.data_byte  = head.data_byte;
    assign o_out_ch.status     = head.status;
    assign o_out_ch.byte_count = head.byte_count;
    assign o_out_ch.last       = head.last;

endmodule

@@ rtl/pwlr_checker.sv @@
`timescale 1ns / 1ps
module pwlr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_kind,
    input logic [pwlr_pkg::DATA_W-1:0]   i_data_byte,
    input logic [pwlr_pkg::STATUS_W-1:0] i_status,
    input logic [pwlr_pkg::BCOUNT_W-1:0] i_byte_count,
    input logic                          i_last
);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == pwlr_pkg::KIND_END) |-> (i_last && i_data_byte == '0))
        else $error("end-of-packet result not last or carries data");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == pwlr_pkg::KIND_BYTE)
            |-> (i_status == pwlr_pkg::ST_OK && i_byte_count == '0))
        else $error("byte result carries status or count");

    a_bad_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != pwlr_pkg::ST_OK) |-> (i_byte_count == '0))
        else $error("failed packet reports a byte count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind)
            && $stable(i_data_byte) && $stable(i_status)
            && $stable(i_byte_count) && $stable(i_last)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind pulse_width_line_receiver_top pwlr_checker u_pwlr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_kind       (o_out_ch.kind),
    .i_data_byte  (o_out_ch.data_byte),
    .i_status     (o_out_ch.status),
    .i_byte_count (o_out_ch.byte_count),
    .i_last       (o_out_ch.last)
);
